// File: hdl/pqe_pkg.sv
// Shared types and constants for the product-quantization encoder.
// Used by all modules in hdl; no dependencies.
package pqe_pkg;

   localparam int VAL_W  = 16;
   localparam int DIST_W = 38;
   localparam int SQ_W   = 34;

   localparam int MAX_CENTROIDS = 256;

   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_ENCODE = 1'b1;

   localparam logic [1:0] REG_SEGMENTS  = 2'd0;
   localparam logic [1:0] REG_SUBDIM    = 2'd1;
   localparam logic [1:0] REG_CENTROIDS = 2'd2;

   typedef struct packed {
      logic              operation;
      logic [2:0]        load_segment;
      logic [7:0]        load_centroid;
      logic [3:0]        load_element;
      logic signed [15:0] value;
   } req_payload_type;

   typedef struct packed {
      logic [2:0] segment_index;
      logic [7:0] code;
      logic       last_segment;
   } rsp_payload_type;

   // Control handed from the sequencer to every cell.
   typedef struct packed {
      logic step;      // accumulate this element
      logic first;     // element 0: restart the sum
      logic shift;     // move sums one cell toward the comparator
   } cell_ctrl_type;

endpackage

// File: hdl/pqe_cell.sv
// One centroid cell: codebook slice, squared difference, running sum.
// Depends on pqe_pkg.
module pqe_cell
   import pqe_pkg::*;
#(
   parameter int SEGS   = 8,
   parameter int SUBDIM = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_use,
   input  logic                   wr_en,
   input  logic [$clog2(SEGS*SUBDIM)-1:0] wr_addr,
   input  logic [$clog2(SEGS*SUBDIM)-1:0] rd_addr,
   input  logic signed [VAL_W-1:0] wr_data,
   input  logic signed [VAL_W-1:0] x_ff_val,
   input  cell_ctrl_type          ctrl,
   input  logic [DIST_W-1:0]      sum_from_next,
   output logic [DIST_W-1:0]      sum_out
);
   localparam int DEPTH = SEGS * SUBDIM;
   localparam logic [DIST_W-1:0] SAT = {DIST_W{1'b1}};

   logic signed [VAL_W-1:0] mem [DEPTH];
   logic signed [VAL_W-1:0] word_ff;
   logic [SQ_W-1:0]   sq;
   logic signed [VAL_W:0] diff;
   logic [VAL_W:0]    ad;
   logic [DIST_W-1:0] acc;
   logic [DIST_W:0]   tot;
   logic [DIST_W-1:0] sum_ff, sum_in;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      word_ff <= mem[rd_addr];
      if (reset) begin
         sum_ff <= '0;
      end else begin
         sum_ff <= sum_in;
      end
   end

   always_comb begin
      diff = {x_ff_val[VAL_W-1], x_ff_val} - {word_ff[VAL_W-1], word_ff};
      ad   = diff[VAL_W] ? (~diff + 1'b1) : diff;
      sq   = SQ_W'(ad * ad);
      acc  = ctrl.first ? '0 : sum_ff;
      tot  = {1'b0, acc} + {{(DIST_W+1-SQ_W){1'b0}}, sq};
      sum_in = sum_ff;
      // Cells past the centroids in use hold their sums untouched.
      if (in_use) begin
         if (ctrl.step) begin
            sum_in = tot[DIST_W] ? SAT : tot[DIST_W-1:0];
         end else if (ctrl.shift) begin
            sum_in = sum_from_next;
         end
      end
   end

   assign sum_out = sum_ff;
endmodule

// File: hdl/product_quantizer_encoder.sv
// Product-quantization encoder top level. Depends on pqe_pkg, pqe_cell.
// Loads are taken back to back while idle; an encode element has a codebook read and an
// accumulate step. Segment end: the sums rotate past the chain head one per cycle into a
// running minimum; ST_OUT then registers the code and returns to idle, so the next request
// can be taken while the code is valid; ST_OUT holds while an earlier code still waits.
// Reset (synchronous, active high) clears positions, sums, output valid; registers 8/16/256.
module product_quantizer_encoder
   import pqe_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_data,
   input  logic            csr_psel,
   input  logic            csr_penable,
   input  logic            csr_pwrite,
   input  logic [3:0]      csr_paddr,
   input  logic [31:0]     csr_pwdata,
   output logic [31:0]     csr_prdata,
   output logic            csr_pready
);
   localparam int SEGS = 8;
   localparam int SUB  = 16;
   localparam int AW   = $clog2(SEGS*SUB);
   localparam int NC   = MAX_CENTROIDS;
   localparam int CW   = $clog2(NC+1);

   typedef enum logic [1:0] {ST_IDLE, ST_ACC, ST_SCAN, ST_OUT} state_type;

   state_type state_ff;
   logic [3:0] segs_ff;
   logic [4:0] sub_ff;
   logic [8:0] cents_ff;
   logic [3:0] epos_ff;
   logic [2:0] spos_ff;
   logic [CW-1:0] cnt_ff;
   logic [DIST_W-1:0] min_ff;
   logic [7:0] best_ff;
   logic first_ff, last_ff;
   logic signed [VAL_W-1:0] x_ff;
   rsp_payload_type rsp_ff;
   logic rsp_valid_ff;

   logic [3:0] segs_c;
   logic [4:0] sub_c;
   logic [CW-1:0] cents_c;
   logic [2:0] s_c;
   logic [3:0] e_c;
   logic acc_req, load_req, cfg_wr, out_go;
   cell_ctrl_type ctrl;
   logic [DIST_W-1:0] sums [NC+1];

   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   always_comb begin
      unique case (csr_paddr[3:2])
         REG_SEGMENTS:  csr_prdata = {28'd0, segs_ff};
         REG_SUBDIM:    csr_prdata = {27'd0, sub_ff};
         REG_CENTROIDS: csr_prdata = {23'd0, cents_ff};
         default:       csr_prdata = '0;
      endcase
   end

   // Clamp registers to legal ranges.
   always_comb begin
      segs_c  = (segs_ff == 0) ? 4'd1 : (segs_ff > SEGS) ? 4'(SEGS) : segs_ff;
      sub_c   = (sub_ff == 0) ? 5'd1 : (sub_ff > SUB) ? 5'(SUB) : sub_ff;
      cents_c = (cents_ff == 0) ? CW'(1)
              : (32'(cents_ff) > NC) ? CW'(NC) : CW'(cents_ff);
      s_c = spos_ff;
      e_c = epos_ff;
   end

   // Take one request only when idle; a waiting code holds the sequencer in
   // ST_OUT, not the input.
   assign req_stall = (state_ff != ST_IDLE);
   assign load_req  = req_valid && !req_stall && req_data.operation == OP_LOAD;
   assign acc_req   = req_valid && !req_stall && req_data.operation == OP_ENCODE;
   assign out_go    = (state_ff == ST_OUT) && (!rsp_valid_ff || !rsp_stall);

   assign ctrl.step  = (state_ff == ST_ACC);
   assign ctrl.first = first_ff;
   assign ctrl.shift = (state_ff == ST_SCAN);

   // The last cell in use takes the head's sum, so a full scan rotates
   // every sum back to its own cell.
   assign sums[NC] = {DIST_W{1'b1}};
   for (genvar c = 0; c < NC; c++) begin : g_cell
      logic wr, in_use, tail;
      assign wr     = load_req && (32'(req_data.load_centroid) == c);
      assign in_use = (32'(cents_c) > c);
      assign tail   = (32'(cents_c) == c + 1);
      pqe_cell #(.SEGS(SEGS), .SUBDIM(SUB)) u_cell (
         .clock         (clock),
         .reset         (reset),
         .in_use        (in_use),
         .wr_en         (wr),
         .wr_addr       (AW'({req_data.load_segment, req_data.load_element})),
         .rd_addr       (AW'({s_c, e_c})),
         .wr_data       (req_data.value),
         .x_ff_val      (x_ff),
         .ctrl          (ctrl),
         .sum_from_next (tail ? sums[0] : sums[c+1]),
         .sum_out       (sums[c])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         segs_ff      <= 4'd8;
         sub_ff       <= 5'd16;
         cents_ff     <= 9'd256;
         epos_ff      <= '0;
         spos_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cfg_wr) begin
            unique case (csr_paddr[3:2])
               REG_SEGMENTS:  segs_ff  <= csr_pwdata[3:0];
               REG_SUBDIM:    sub_ff   <= csr_pwdata[4:0];
               REG_CENTROIDS: cents_ff <= csr_pwdata[8:0];
               default: ;
            endcase
         end
         if (out_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               // Positions past a shrunk register stay as they are; the
               // element is then the last one of its segment.
               if (acc_req) begin
                  x_ff     <= req_data.value;
                  state_ff <= ST_ACC;
               end
            end
            ST_ACC: begin
               if (5'(epos_ff) + 5'd1 < sub_c) begin
                  epos_ff  <= epos_ff + 4'd1;
                  state_ff <= ST_IDLE;
               end else begin
                  last_ff  <= (4'(spos_ff) + 4'd1 >= segs_c);
                  cnt_ff   <= '0;
                  min_ff   <= {DIST_W{1'b1}};
                  best_ff  <= '0;
                  state_ff <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               // Head of the chain is centroid cnt_ff; strict less keeps first.
               if (sums[0] < min_ff) begin
                  min_ff  <= sums[0];
                  best_ff <= 8'(cnt_ff);
               end
               if (cnt_ff + CW'(1) >= cents_c) state_ff <= ST_OUT;
               cnt_ff <= cnt_ff + CW'(1);
            end
            ST_OUT: begin
               // Hold the code while the previous one still waits.
               if (out_go) begin
                  rsp_ff.segment_index <= spos_ff;
                  rsp_ff.code          <= best_ff;
                  rsp_ff.last_segment  <= last_ff;
                  epos_ff              <= '0;
                  spos_ff              <= last_ff ? 3'd0 : spos_ff + 3'd1;
                  state_ff             <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // first flag is registered with the accepted element.
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && acc_req) begin
         first_ff <= (epos_ff == 4'd0);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule

// File: hdl/pqe_checker.sv
// Port-level checker for product_quantizer_encoder, bound to the top level.
// Depends on pqe_pkg.
module pqe_checker
   import pqe_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            req_stall,
   input logic            rsp_valid,
   input logic            rsp_stall,
   input rsp_payload_type rsp_data
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");
   a_rsp_known: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$isunknown(rsp_data))
      else $error("result payload unknown while valid");
   a_ctrl_known: assert property (@(posedge clock) disable iff (reset)
      !$isunknown({req_stall, rsp_valid}))
      else $error("handshake output unknown");
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");
endmodule

bind product_quantizer_encoder pqe_checker u_pqe_checker (
   .clock(clock), .reset(reset), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
);
